// ===== sv/bdeq_pkg.sv =====
// shared types, sizes and codes for the bounded double-ended queue
package bdeq_pkg;

    // storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    // word field widths
    localparam int ACTION_W    = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int READ_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_FIELDS_W = ACTION_W + VALUE_W + POS_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = READ_W + COUNT_W + 2 + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_READ       = 3'd4,
        ACT_CLEAR      = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        K_PUSH_BACK,
        K_PUSH_FRONT,
        K_POP_BACK,
        K_POP_FRONT,
        K_READ,
        K_CLEAR,
        K_NOP
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        WS_ZERO,
        WS_MEM,
        WS_VALUE
    } t_word_src;

    typedef enum logic {
        BK_IDLE,
        BK_RESP
    } t_back_state;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    position;
    } t_cmd;

    typedef struct packed {
        logic                valid;
        t_cmd                cmd;
    } t_cmd_slot;

    typedef struct packed {
        logic [READ_W-1:0]   read_value;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
        logic                is_full;
        t_status             status;
    } t_result;

endpackage

// ===== sv/bdeq_front.sv =====
// input side: takes words off the slave stream and decodes the action
module bdeq_front
    import bdeq_pkg::*;
(
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,   // action, value, position
    input  logic                  i_fifo_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [ACTION_W-1:0] w_action;
    t_kind               w_kind;

    assign w_action   = i_s_tdata[ACTION_W-1:0];
    assign o_s_tready = i_rst_n && !i_fifo_full;
    assign o_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        case (w_action)
            ACT_PUSH_BACK:  w_kind = K_PUSH_BACK;
            ACT_PUSH_FRONT: w_kind = K_PUSH_FRONT;
            ACT_POP_BACK:   w_kind = K_POP_BACK;
            ACT_POP_FRONT:  w_kind = K_POP_FRONT;
            ACT_READ:       w_kind = K_READ;
            ACT_CLEAR:      w_kind = K_CLEAR;
            default:        w_kind = K_NOP;
        endcase
    end

    always_comb begin
        o_cmd.kind     = w_kind;
        o_cmd.value    = i_s_tdata[ACTION_W +: VALUE_W];
        o_cmd.position = i_s_tdata[ACTION_W + VALUE_W +: POS_W];
    end

endmodule

// ===== sv/bdeq_cmd_fifo.sv =====
// two-entry command queue between the decoder and the executing back end
module bdeq_cmd_fifo
    import bdeq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  logic      i_pop,
    output t_cmd_slot o_head
);

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_fill;
    logic       w_do_pop;

    assign o_full       = (r_fill == 2'd2);
    assign w_do_pop     = i_pop && (r_fill != 2'd0);
    assign o_head.valid = (r_fill != 2'd0);
    assign o_head.cmd   = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_do_pop ? !r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + {1'b0, i_push} - {1'b0, w_do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/bdeq_back.sv =====
// back end: ring store, head and count, result build and output register
module bdeq_back
    import bdeq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_slot i_head,
    output logic      o_pop,
    output logic      o_m_tvalid,
    input  logic      i_m_tready,
    output t_result   o_result
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    t_back_state r_state;
    t_back_state n_state;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    t_word_src             r_src;
    t_word_src             n_src;
    logic [DATA_WIDTH-1:0] r_pend_value;
    t_status               r_pend_status;
    t_status               n_status;

    t_result r_out;
    t_result w_out;
    logic    r_out_valid;

    logic                  w_issue;
    logic                  w_load;
    logic                  w_empty;
    logic                  w_full;
    logic                  w_we;
    logic [PTR_W-1:0]      w_waddr;
    logic [PTR_W-1:0]      w_raddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [PTR_W-1:0]      w_tail;
    logic [PTR_W-1:0]      w_last;
    logic [PTR_W-1:0]      w_head_dec;
    logic [PTR_W-1:0]      w_head_inc;
    logic [PTR_W-1:0]      w_indexed;
    logic [DATA_WIDTH-1:0] w_word;

    function automatic logic [PTR_W-1:0] f_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] lim;
        lim = SUM_W'(DEPTH);
        return (s >= lim) ? PTR_W'(s - lim) : PTR_W'(s);
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_head.valid) n_state = BK_RESP;
            BK_RESP: if (!r_out_valid || i_m_tready) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_issue = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            BK_IDLE: w_issue = i_head.valid;
            BK_RESP: w_load  = !r_out_valid || i_m_tready;
            default: begin
                w_issue = 1'b0;
                w_load  = 1'b0;
            end
        endcase
    end

    assign o_pop   = w_issue;
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_wdata = DATA_WIDTH'(i_head.cmd.value);

    // ring addresses around the head
    always_comb begin
        w_tail     = f_wrap(SUM_W'(r_head) + SUM_W'(r_count));
        w_last     = f_wrap(SUM_W'(r_head) + SUM_W'(r_count) - SUM_W'(1));
        w_head_dec = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - PTR_W'(1);
        w_head_inc = f_wrap(SUM_W'(r_head) + SUM_W'(1));
        w_indexed  = f_wrap(SUM_W'(r_head) + SUM_W'(i_head.cmd.position));
    end

    // action decode into store access and pointer update
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        n_src    = WS_ZERO;
        w_we     = 1'b0;
        w_waddr  = w_tail;
        w_raddr  = r_head;
        case (i_head.cmd.kind)
            K_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                    n_src    = WS_MEM;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    // pushing onto an empty queue makes the new word the front
                    n_src   = w_empty ? WS_VALUE : WS_MEM;
                end
            end
            K_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                    n_src    = WS_MEM;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_head_dec;
                    n_head  = w_head_dec;
                    n_count = r_count + CNT_W'(1);
                    n_src   = WS_VALUE;
                end
            end
            K_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    w_raddr = w_last;
                    n_count = r_count - CNT_W'(1);
                    n_src   = WS_MEM;
                end
            end
            K_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_head  = w_head_inc;
                    n_count = r_count - CNT_W'(1);
                    n_src   = WS_MEM;
                end
            end
            K_READ: begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else if (SUM_W'(i_head.cmd.position) >= SUM_W'(r_count)) begin
                    n_status = ST_RANGE;
                end else begin
                    w_raddr = w_indexed;
                    n_src   = WS_MEM;
                end
            end
            K_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            K_NOP: begin
                n_src = w_empty ? WS_ZERO : WS_MEM;
            end
            default: begin
                n_src = WS_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we && w_issue) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_issue) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_src         <= n_src;
            r_pend_value  <= w_wdata;
            r_pend_status <= n_status;
        end
        if (w_load) begin
            r_out <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_issue) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word, count already holds its post-action value
    always_comb begin
        case (r_src)
            WS_MEM:   w_word = r_rdata;
            WS_VALUE: w_word = r_pend_value;
            default:  w_word = '0;
        endcase
        w_out.read_value = READ_W'(w_word);
        w_out.count      = COUNT_W'(r_count);
        w_out.is_empty   = (r_count == '0);
        w_out.is_full    = (r_count == CNT_W'(DEPTH));
        w_out.status     = r_pend_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && i_head.cmd.kind == K_CLEAR) |=> (r_count == '0 && r_head == '0))
        else $error("clear did not reset head and count");

    a_resp_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RESP) |-> (!w_issue && !o_pop))
        else $error("new action issued while a result is pending");

    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_empty == (r_out.count == '0)))
        else $error("empty flag disagrees with count");

endmodule

// ===== sv/bounded_double_ended_queue_unit.sv =====
// top level of the bounded double-ended queue: decoder, command queue, ring store
// A 16-entry double-ended queue of 32-bit words driven by one action per input
// word (push back/front, pop back/front, read by index, clear); each action
// returns one result word with the data, the count after the action, empty and
// full flags and a status code. An action is decoded and written into the
// two-entry command queue at the edge that accepts it, then goes to the back end,
// which first issues its access to the ring store and then, once the output
// register is free, builds the result from the registered store read; the back
// end issues the next action only after that result is loaded. The command queue
// and the output register let the input keep flowing while a result waits
// downstream, until the command queue fills. Action codes six and seven are
// treated as no-ops.
module bounded_double_ended_queue_unit
    import bdeq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // action[2:0], value[34:3], position[38:35]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // read_value, count, is_empty, is_full, status
);

    logic      w_push;
    logic      w_fifo_full;
    logic      w_pop;
    t_cmd      w_cmd;
    t_cmd_slot w_head;
    t_result   w_result;

    bdeq_front u_front (
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_fifo_full (w_fifo_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    bdeq_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_fifo_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    bdeq_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (w_result)
    );

    assign o_m_tdata = {
        {(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
        w_result.status,
        w_result.is_full,
        w_result.is_empty,
        w_result.count,
        w_result.read_value
    };

endmodule

// ===== sim/bounded_double_ended_queue_unit_tb.sv =====
// testbench for the bounded double-ended queue unit: table of directed actions, random traffic
module bounded_double_ended_queue_unit_tb
    import bdeq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACTION_W-1:0] ACT_SPARE_SIX   = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_SEVEN = 3'd7;
    localparam int RANDOM_WORDS = 750;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [READ_W-1:0]  read_value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
        t_status            status;
    } t_deque_result;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    position;
        bit                  typed;
        logic [READ_W-1:0]   read_value;
        logic [COUNT_W-1:0]  count;
        t_status             status;
    } t_action_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // action[2:0], value[34:3], position[38:35]
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // read_value[31:0], count[36:32], is_empty[37],
                                         // is_full[38], status[40:39]

    // shadow copy of the queue
    logic [VALUE_W-1:0] ring_words [DEPTH];
    logic [PTR_W-1:0]   front_slot;
    logic [CNT_W-1:0]   held_words;

    t_deque_result pending_results [$];
    t_action_row   action_plan [$];

    bit calm_stretch;
    int words_sent, results_checked, mismatches, stray_results, cycles;
    int refused_pushes, underflows, range_misses, clears, spare_codes;

    bounded_double_ended_queue_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_deque_result deque_apply(input logic [ACTION_W-1:0] action,
                                                  input logic [VALUE_W-1:0] value,
                                                  input logic [POS_W-1:0] position);
        t_deque_result res;
        logic          show_front;
        logic [PTR_W-1:0] slot;
        res.read_value = '0;
        res.status     = ST_OK;
        show_front     = 1'b0;
        case (action)
            ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                if (held_words == DEPTH) begin
                    res.status = ST_OVERFLOW;
                    refused_pushes++;
                end else if (action == ACT_PUSH_BACK) begin
                    slot = front_slot + held_words[PTR_W-1:0];
                    ring_words[slot] = value;
                    held_words++;
                end else begin
                    front_slot = front_slot - 1'b1;
                    ring_words[front_slot] = value;
                    held_words++;
                end
                show_front = 1'b1;
            end
            ACT_POP_BACK: begin
                if (held_words == 0) begin
                    res.status = ST_UNDERFLOW;
                    underflows++;
                end else begin
                    slot = front_slot + held_words[PTR_W-1:0] - 1'b1;
                    res.read_value = ring_words[slot];
                    held_words--;
                end
            end
            ACT_POP_FRONT: begin
                if (held_words == 0) begin
                    res.status = ST_UNDERFLOW;
                    underflows++;
                end else begin
                    res.read_value = ring_words[front_slot];
                    front_slot = front_slot + 1'b1;
                    held_words--;
                end
            end
            ACT_READ: begin
                if (held_words == 0) begin
                    res.status = ST_UNDERFLOW;
                    underflows++;
                end else if (position >= held_words) begin
                    res.status = ST_RANGE;
                    range_misses++;
                end else begin
                    slot = front_slot + position;
                    res.read_value = ring_words[slot];
                end
            end
            ACT_CLEAR: begin
                front_slot = '0;
                held_words = '0;
                clears++;
            end
            default: begin
                show_front = 1'b1;
                spare_codes++;
            end
        endcase
        if (show_front)
            res.read_value = (held_words == 0) ? '0 : ring_words[front_slot];
        res.count    = held_words;
        res.is_empty = (held_words == 0);
        res.is_full  = (held_words == DEPTH);
        return res;
    endfunction

    function automatic void plan_row(input logic [ACTION_W-1:0] action,
                                     input logic [VALUE_W-1:0] value,
                                     input logic [POS_W-1:0] position, input bit typed,
                                     input logic [READ_W-1:0] read_value,
                                     input logic [COUNT_W-1:0] count, input t_status status);
        t_action_row row;
        row.action     = action;
        row.value      = value;
        row.position   = position;
        row.typed      = typed;
        row.read_value = read_value;
        row.count      = count;
        row.status     = status;
        action_plan.insert(action_plan.size(), row);
    endfunction

    // present one word, hold it until taken, then record what should come back
    task automatic send_word(input logic [ACTION_W-1:0] action, input logic [VALUE_W-1:0] value,
                             input logic [POS_W-1:0] position, input bit typed,
                             input t_deque_result typed_res);
        t_deque_result predicted;
        while (!calm_stretch && $urandom_range(0, 99) < 13) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = '0;
        i_s_tdata[ACTION_W-1:0]                            = action;
        i_s_tdata[ACTION_W+VALUE_W-1:ACTION_W]             = value;
        i_s_tdata[IN_FIELDS_W-1:ACTION_W+VALUE_W]          = position;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = deque_apply(action, value, position);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // receiver side: random back-pressure
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready = calm_stretch || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge i_clk) begin
        t_deque_result want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.read_value = o_m_tdata[READ_W-1:0];
            got.count      = o_m_tdata[READ_W+COUNT_W-1:READ_W];
            got.is_empty   = o_m_tdata[READ_W+COUNT_W];
            got.is_full    = o_m_tdata[READ_W+COUNT_W+1];
            got.status     = t_status'(o_m_tdata[OUT_FIELDS_W-1:READ_W+COUNT_W+2]);
            if (pending_results.size() == 0) begin
                stray_results++;
                if (mismatches + stray_results <= SHOWN_ERRORS)
                    $display("unexpected result word: value=%h count=%0d status=%0d",
                             got.read_value, got.count, got.status);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                results_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches + stray_results <= SHOWN_ERRORS)
                        $display({"mismatch on result %0d: expected value=%h count=%0d ",
                                  "empty=%b full=%b status=%0d, got value=%h count=%0d ",
                                  "empty=%b full=%b status=%0d"}, results_checked,
                                 want.read_value, want.count, want.is_empty, want.is_full,
                                 want.status, got.read_value, got.count, got.is_empty,
                                 got.is_full, got.status);
                end
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_deque_result typed_res;
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    position;
        int roll, push_pct, mode;

        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        calm_stretch = 1'b0;
        front_slot   = '0;
        held_words   = '0;
        foreach (ring_words[k])
            ring_words[k] = '0;

        // empty queue, extreme first words, spare codes, fill and overfill, pop both ends, clear
        plan_row(ACT_POP_FRONT, 32'h0, 4'd0, 1, 32'h0, 5'd0, ST_UNDERFLOW);
        plan_row(ACT_POP_BACK, 32'h1234_5678, 4'd0, 1, 32'h0, 5'd0, ST_UNDERFLOW);
        plan_row(ACT_READ, 32'h0, 4'd0, 1, 32'h0, 5'd0, ST_UNDERFLOW);
        plan_row(ACT_PUSH_BACK, 32'hFFFF_FFFF, 4'd15, 1, 32'hFFFF_FFFF, 5'd1, ST_OK);
        plan_row(ACT_PUSH_FRONT, 32'h0, 4'd0, 1, 32'h0, 5'd2, ST_OK);
        plan_row(ACT_READ, 32'h0, 4'd15, 1, 32'h0, 5'd2, ST_RANGE);
        plan_row(ACT_SPARE_SIX, 32'hDEAD_BEEF, 4'd3, 0, '0, '0, ST_OK);
        plan_row(ACT_SPARE_SEVEN, 32'h0, 4'd0, 0, '0, '0, ST_OK);
        for (int n = 0; n < DEPTH - 2; n++)
            plan_row((n % 2) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, 32'h8000_0001 ^ (n << 8),
                     4'(n), 0, '0, '0, ST_OK);
        plan_row(ACT_PUSH_BACK, 32'h5555_5555, 4'd0, 0, '0, '0, ST_OK);
        plan_row(ACT_PUSH_FRONT, 32'hAAAA_AAAA, 4'd0, 0, '0, '0, ST_OK);
        plan_row(ACT_READ, 32'h0, 4'd15, 0, '0, '0, ST_OK);
        plan_row(ACT_POP_BACK, 32'h0, 4'd0, 0, '0, '0, ST_OK);
        plan_row(ACT_POP_FRONT, 32'h0, 4'd0, 0, '0, '0, ST_OK);
        plan_row(ACT_CLEAR, 32'hFFFF_FFFF, 4'd15, 1, 32'h0, 5'd0, ST_OK);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (action_plan[r]) begin
            typed_res.read_value = action_plan[r].read_value;
            typed_res.count      = action_plan[r].count;
            typed_res.is_empty   = (action_plan[r].count == 0);
            typed_res.is_full    = (action_plan[r].count == DEPTH);
            typed_res.status     = action_plan[r].status;
            send_word(action_plan[r].action, action_plan[r].value, action_plan[r].position,
                      action_plan[r].typed, typed_res);
        end
        i_s_tvalid = 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) begin
                i_s_tvalid = 1'b0;
                wait_drained();
            end
            calm_stretch = (n >= 450 && n < 600);
            // alternate fill-heavy, drain-heavy and balanced phases
            mode = (n / 48) % 3;
            push_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 50;
            roll = $urandom_range(0, 199);
            if (roll == 0)
                action = ACT_CLEAR;
            else if (roll < 5)
                action = $urandom_range(0, 1) ? ACT_SPARE_SEVEN : ACT_SPARE_SIX;
            else if (roll < 35)
                action = ACT_READ;
            else if ($urandom_range(0, 99) < push_pct)
                action = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            else
                action = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
            case ($urandom_range(0, 19))
                0:       value = '0;
                1:       value = '1;
                default: value = $urandom;
            endcase
            if (held_words != 0 && $urandom_range(0, 3) != 0)
                position = POS_W'($urandom_range(0, held_words - 1));
            else
                position = POS_W'($urandom_range(0, 15));
            send_word(action, value, position, 0, typed_res);
        end
        i_s_tvalid   = 1'b0;
        calm_stretch = 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("sent %0d words: %0d refused pushes, %0d underflows, %0d reads past the count,",
                 words_sent, refused_pushes, underflows, range_misses);
        $display("%0d clears, %0d spare codes; %0d results checked, %0d wrong, %0d unexpected",
                 clears, spare_codes, results_checked, mismatches, stray_results);
        if (mismatches == 0 && stray_results == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bdeq_pkg.sv
sv/bdeq_front.sv
sv/bdeq_cmd_fifo.sv
sv/bdeq_back.sv
sv/bounded_double_ended_queue_unit.sv
sim/bounded_double_ended_queue_unit_tb.sv
